@@ hw/rtl/vaa_pkg.sv @@
// Package with shared constants, the arctangent table and the job type for the angle core.
`default_nettype none
package vaa_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int ITERATIONS_DEF  = 16;

    localparam int TURN_BITS = 32;
    localparam int TABLE_LEN = 24;
    localparam int SCALE_POS = 40;
    localparam int DATA_W    = 43;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [TURN_BITS-1:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [TURN_BITS-1:0] HALF_TURN          = 32'h8000_0000;
    localparam logic [TURN_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

    localparam logic [TURN_BITS-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [TURN_BITS-1:0]     z;
        logic                     is_fixed;
    } t_job;

endpackage
`default_nettype wire

@@ hw/rtl/vaa_in_if.sv @@
// Input channel carrying one vector item.
`default_nettype none
interface vaa_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] delta_x;
    logic signed [COORD_WIDTH-1:0] delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vaa_out_if.sv @@
// Output channel carrying one heading item.
`default_nettype none
interface vaa_out_if #(
    parameter int ANGLE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vaa_front.sv @@
// Front stage that accepts vectors, scales them and sorts out the special directions.
`default_nettype none
module vaa_front
    import vaa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_delta_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_delta_y,
    output logic                               o_valid,
    input  wire logic                          i_full,
    output t_job                               o_job
);

    localparam int SCALE_SHIFT = SCALE_POS - COORD_WIDTH;

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;

    always_comb begin
        sx = DATA_W'(i_delta_x) <<< SCALE_SHIFT;
        sy = DATA_W'(i_delta_y) <<< SCALE_SHIFT;
        n_job.is_fixed = 1'b0;
        if (i_delta_x < 0) begin
            n_job.x = -sx;
            n_job.y = sy;
            n_job.z = HALF_TURN;
        end else begin
            n_job.x = sx;
            n_job.y = -sy;
            n_job.z = '0;
        end
        if (i_delta_x == 0) begin
            n_job.is_fixed = 1'b1;
            n_job.z = (i_delta_y <= 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
        end else if (i_delta_y == 0) begin
            n_job.is_fixed = 1'b1;
            n_job.z = (i_delta_x > 0) ? '0 : HALF_TURN;
        end
    end

    assign o_ready = !r_valid || !i_full;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/vaa_fifo.sv @@
// Short queue of jobs between the front stage and the rotation pipeline.
`default_nettype none
module vaa_fifo
    import vaa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/vaa_back.sv @@
// Unrolled rotation pipeline with per-stage stall control and a rounding output register.
`default_nettype none
module vaa_back
    import vaa_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_pop,
    input  wire t_job               i_job,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [ANGLE_BITS-1:0]   o_heading
);

    localparam logic [TURN_BITS-1:0] ROUND_HALF =
        TURN_BITS'(1) << (TURN_BITS - ANGLE_BITS - 1);

    t_job r_job [ITERATIONS];
    logic r_sv  [ITERATIONS];
    t_job src_job [ITERATIONS];
    logic src_v   [ITERATIONS];
    t_job n_job   [ITERATIONS];
    logic adv     [ITERATIONS+1];

    logic                  r_ov;
    logic [ANGLE_BITS-1:0] r_head;
    logic [TURN_BITS-1:0]  rounded;

    assign adv[ITERATIONS] = !r_ov || i_ready;

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign src_job[k] = i_job;
            assign src_v[k]   = i_valid;
        end else begin : g_next
            assign src_job[k] = r_job[k-1];
            assign src_v[k]   = r_sv[k-1];
        end

        assign adv[k] = !r_sv[k] || adv[k+1];

        always_comb begin
            n_job[k] = src_job[k];
            if (!src_job[k].is_fixed) begin
                if (src_job[k].y > 0) begin
                    n_job[k].x = src_job[k].x + (src_job[k].y >>> k);
                    n_job[k].y = src_job[k].y - (src_job[k].x >>> k);
                    n_job[k].z = src_job[k].z + ATAN_TURNS[k];
                end else begin
                    n_job[k].x = src_job[k].x - (src_job[k].y >>> k);
                    n_job[k].y = src_job[k].y + (src_job[k].x >>> k);
                    n_job[k].z = src_job[k].z - ATAN_TURNS[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (adv[k]) begin
                r_sv[k] <= src_v[k];
            end
            if (adv[k] && src_v[k]) begin
                r_job[k] <= n_job[k];
            end
        end
    end

    assign o_pop   = i_valid && adv[0];
    assign rounded = r_job[ITERATIONS-1].z + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv[ITERATIONS]) begin
            r_ov <= r_sv[ITERATIONS-1];
        end
        if (adv[ITERATIONS] && r_sv[ITERATIONS-1]) begin
            r_head <= rounded[TURN_BITS-1 -: ANGLE_BITS];
        end
    end

    assign o_valid   = r_ov;
    assign o_heading = r_head;

endmodule
`default_nettype wire

@@ hw/rtl/vector_angle_atan2_core.sv @@
// A vector passes the front register, the queue, the rotation stages and the output register.
// Throughput: one vector per cycle while output is taken; one unrolled stage per iteration.
// Front register, two-entry queue and each pipeline stage stall on their own when output waits.
// Reset (synchronous, active low) empties every stage and the queue; no clearing pass is needed.
`default_nettype none
module vector_angle_atan2_core
    import vaa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int ITERATIONS  = ITERATIONS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vaa_in_if.sink     i_vec,
    vaa_out_if.source  o_head
);

    logic front_valid;
    t_job front_job;
    logic q_full;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    vaa_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_vec.valid),
        .o_ready   (i_vec.ready),
        .i_delta_x (i_vec.delta_x),
        .i_delta_y (i_vec.delta_y),
        .o_valid   (front_valid),
        .i_full    (q_full),
        .o_job     (front_job)
    );

    vaa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    vaa_back #(
        .ANGLE_BITS(ANGLE_BITS),
        .ITERATIONS(ITERATIONS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_pop     (q_pop),
        .i_job     (q_job),
        .o_valid   (o_head.valid),
        .i_ready   (o_head.ready),
        .o_heading (o_head.heading)
    );

endmodule
`default_nettype wire

@@ tb/sv/vector_angle_atan2_core_test.sv @@
// Self-checking testbench of vector_angle_atan2_core with random traffic and a CORDIC predictor.
module vector_angle_atan2_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vaa_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int AB = ANGLE_BITS_DEF;
    localparam int RANDOM_VECTORS = 1950;
    localparam int DRAIN_AT = 1200;
    localparam int CALM_FROM = 400;
    localparam int CALM_TO = 700;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } vector_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vaa_in_if #(.COORD_WIDTH(CW)) vec_if ();
    vaa_out_if #(.ANGLE_BITS(AB)) head_if ();

    vector_angle_atan2_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_if.sink),
        .o_head  (head_if.source)
    );

    vector_t vector_q[$];
    logic [AB-1:0] heading_q[$];
    vector_t next_vec;
    int sent_count = 0;
    int directed_count = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    logic calm;
    logic draining;

    assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
    assign draining = (sent_count == directed_count || sent_count == DRAIN_AT)
                      && (vec_if.valid || heading_q.size() != 0);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [AB-1:0] heading_of(input logic signed [CW-1:0] dx,
                                                 input logic signed [CW-1:0] dy);
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic [TURN_BITS-1:0] z;
        logic [TURN_BITS-1:0] rounded;
        int i;
        if (dx == 0) begin
            z = (dy <= 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
        end else if (dy == 0) begin
            z = (dx > 0) ? '0 : HALF_TURN;
        end else begin
            x = longint'(dx) <<< (SCALE_POS - CW);
            y = -(longint'(dy) <<< (SCALE_POS - CW));
            z = '0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (i = 0; i < ITERATIONS_DEF && i < TABLE_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TURNS[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TURNS[i];
                end
            end
        end
        rounded = z + (32'd1 << (TURN_BITS - AB - 1));
        return rounded[TURN_BITS-1 -: AB];
    endfunction

    function automatic logic signed [CW-1:0] extreme_coord();
        case ($urandom_range(4))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return '1;
            3: return CW'(1);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic vector_t random_vector();
        vector_t v;
        int unsigned pick;
        pick = $urandom_range(99);
        v.dx = CW'($urandom);
        v.dy = CW'($urandom);
        if (pick < 20) begin
            v.dx = CW'($urandom_range(16) - 8);
            v.dy = CW'($urandom_range(16) - 8);
        end else if (pick < 30) begin
            if ($urandom_range(1) == 0) v.dx = '0;
            else v.dy = '0;
        end else if (pick < 40) begin
            v.dx = extreme_coord();
            v.dy = extreme_coord();
        end else if (pick < 50) begin
            v.dy = ($urandom_range(1) == 0) ? v.dx : -v.dx;
        end
        return v;
    endfunction

    task automatic queue_vector(input int dx, input int dy);
        vector_t v;
        v.dx = CW'(dx);
        v.dy = CW'(dy);
        vector_q.push_back(v);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vec_if.valid <= 1'b0;
            vec_if.delta_x <= '0;
            vec_if.delta_y <= '0;
        end else if (!vec_if.valid || vec_if.ready) begin
            if (vector_q.size() != 0 && !draining && (calm || $urandom_range(99) >= 27)) begin
                next_vec = vector_q.pop_front();
                vec_if.valid <= 1'b1;
                vec_if.delta_x <= next_vec.dx;
                vec_if.delta_y <= next_vec.dy;
                sent_count <= sent_count + 1;
            end else begin
                vec_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_if.ready <= 1'b0;
        end else begin
            head_if.ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        logic [AB-1:0] want;
        if (i_rst_n) begin
            if (vec_if.valid && vec_if.ready) begin
                heading_q.push_back(heading_of(vec_if.delta_x, vec_if.delta_y));
            end
            if (head_if.valid && head_if.ready) begin
                if (heading_q.size() == 0) begin
                    report_mismatch($sformatf("heading %h with no vector pending",
                                              head_if.heading));
                end else begin
                    want = heading_q.pop_front();
                    if (head_if.heading !== want) begin
                        report_mismatch($sformatf("heading %h, expected %h",
                                                  head_if.heading, want));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((vec_if.valid && vec_if.ready) || (head_if.valid && head_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer.", quiet_cycles);
                $display("vector_angle_atan2_core_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        vec_if.valid = 1'b0;
        vec_if.delta_x = '0;
        vec_if.delta_y = '0;
        head_if.ready = 1'b0;

        queue_vector(0, 0);
        queue_vector(0, -1);
        queue_vector(0, 1);
        queue_vector(0, -32768);
        queue_vector(0, 32767);
        queue_vector(1, 0);
        queue_vector(-1, 0);
        queue_vector(32767, 0);
        queue_vector(-32768, 0);
        queue_vector(32767, 32767);
        queue_vector(-32768, -32768);
        queue_vector(-32768, 32767);
        queue_vector(32767, -32768);
        queue_vector(1, 1);
        queue_vector(-1, -1);
        queue_vector(1, -1);
        queue_vector(-1, 1);
        queue_vector(5, -5);
        queue_vector(-32768, 1);
        queue_vector(1, -32768);
        queue_vector(100, -173);
        queue_vector(-3, 7);
        directed_count = vector_q.size();
        repeat (RANDOM_VECTORS) vector_q.push_back(random_vector());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (vector_q.size() != 0 || vec_if.valid || heading_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (heading_q.size() != 0) begin
            report_mismatch($sformatf("%0d headings never arrived", heading_q.size()));
        end

        if (mismatches == 0) begin
            $display("vector_angle_atan2_core_test OK");
        end else begin
            $display("vector_angle_atan2_core_test NOT OK");
        end
        $finish;
    end
endmodule
